/* rtl/hbt_pkg.sv */
// Shared types, codes and constants for the heartbeat timeout table.
package hbt_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 32;

    localparam int unsigned ID_W      = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned TMO_W     = 16;
    localparam int unsigned LIMIT_W   = 8;
    localparam int unsigned MISS_W    = 8;
    localparam int unsigned LIVE_W    = 6;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_W     = 16;

    localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 16'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 8'd3;
    localparam logic [MISS_W-1:0]  MISS_MAX      = 8'hFF;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_REFRESH = 2'd2,
        OP_SWEEP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_CLOSE  = 2'd1,
        KIND_LIVE   = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT = 1'd0,
        CFG_LIMIT   = 1'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_OP,
        S_SW_SCAN,
        S_SW_CHK,
        S_SW_UPD,
        S_SW_EMIT,
        S_SW_LIVE
    } state_t;

    typedef struct packed {
        logic load;
        logic do_op;
        logic sw_read;
        logic sw_check;
        logic sw_update;
        logic advance;
        logic emit_close;
        logic emit_live;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_sweep;
        logic idx_valid;
        logic idx_last;
        logic close_pending;
        logic out_free;
    } ctrl_sts_t;

endpackage

/* rtl/heartbeat_timeout_table_unit.sv */
// Top level of the heartbeat timeout table: controller plus datapath.
//
// Input channel s_*: one word holds an operation (add, remove, refresh, sweep),
// a connection id and the current time in seconds. Result channel m_*: status,
// close request or live count words; m_last marks the final word of an item.
// cfg_we/cfg_index/cfg_wdata write timeout_seconds (0) and miss_limit (1);
// write them only while the block is idle.
// Add, remove and refresh: the word is taken in S_IDLE, S_DISPATCH picks the path,
// S_OP registers the status word once the output register is free, and the
// next word is taken back in S_IDLE. A sweep walks the table one entry at a time
// through the single-port entry memory: an empty entry is skipped in S_SW_SCAN; a
// valid entry is read there, then checked, updated and possibly closed in S_SW_CHK,
// S_SW_UPD and S_SW_EMIT; S_SW_LIVE then sends the live count word.
// Reset clears the valid and alive marks and loads the config defaults
// (timeout 1, miss limit 3); no clearing pass is needed.
// The result is held in an output register; while the receiver stalls the
// sweep pauses on the next word, and one input word may be taken while the
// last result of the previous item still waits.
module heartbeat_timeout_table_unit #(
    parameter int unsigned TABLE_DEPTH = hbt_pkg::DEF_TABLE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [hbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hbt_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic [hbt_pkg::ID_W-1:0]      s_connection_id,
    input  logic [hbt_pkg::TIME_W-1:0]    s_now_seconds,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_result_kind,
    output logic [hbt_pkg::ID_W-1:0]      m_target_id,
    output logic                          m_ok,
    output logic [hbt_pkg::LIVE_W-1:0]    m_live_count,
    output logic                          m_last
);
    import hbt_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    hbt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    hbt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_operation     (s_operation),
        .s_connection_id (s_connection_id),
        .s_now_seconds   (s_now_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_target_id     (m_target_id),
        .m_ok            (m_ok),
        .m_live_count    (m_live_count),
        .m_last          (m_last),
        .cmd             (cmd),
        .sts             (sts)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in flight");

    a_live_word_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == KIND_LIVE)) |->
            (m_last && !m_ok && (m_target_id == '0)))
        else $error("malformed live count word");

    a_close_word_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == KIND_CLOSE)) |->
            (!m_last && !m_ok && (m_live_count == '0)
             && (m_target_id < ID_W'(TABLE_DEPTH))))
        else $error("malformed close request word");

    a_status_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == KIND_STATUS)) |-> (m_last && (m_live_count == '0)))
        else $error("status word not final");
`endif

endmodule

/* rtl/hbt_ctrl.sv */
// Controller state machine sequencing table operations and sweeps.
module hbt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hbt_pkg::ctrl_sts_t sts,
    output hbt_pkg::ctrl_cmd_t cmd
);
    import hbt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                state_next = sts.is_sweep ? S_SW_SCAN : S_OP;
            end
            S_OP: begin
                if (sts.out_free) begin
                    cmd.do_op  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SW_SCAN: begin
                if (sts.idx_valid) begin
                    cmd.sw_read = 1'b1;
                    state_next  = S_SW_CHK;
                end else if (sts.idx_last) begin
                    state_next = S_SW_LIVE;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            S_SW_CHK: begin
                cmd.sw_check = 1'b1;
                state_next   = S_SW_UPD;
            end
            S_SW_UPD: begin
                cmd.sw_update = 1'b1;
                state_next    = S_SW_EMIT;
            end
            S_SW_EMIT: begin
                if (!sts.close_pending || sts.out_free) begin
                    cmd.emit_close = sts.close_pending;
                    if (sts.idx_last) begin
                        state_next = S_SW_LIVE;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = S_SW_SCAN;
                    end
                end
            end
            S_SW_LIVE: begin
                if (sts.out_free) begin
                    cmd.emit_live = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/hbt_dpath.sv */
// Datapath: entry table, config registers, sweep arithmetic and result register.
module hbt_dpath #(
    parameter int unsigned TABLE_DEPTH = hbt_pkg::DEF_TABLE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [hbt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hbt_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [1:0]                        s_operation,
    input  logic [hbt_pkg::ID_W-1:0]          s_connection_id,
    input  logic [hbt_pkg::TIME_W-1:0]        s_now_seconds,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_result_kind,
    output logic [hbt_pkg::ID_W-1:0]          m_target_id,
    output logic                              m_ok,
    output logic [hbt_pkg::LIVE_W-1:0]        m_live_count,
    output logic                              m_last,
    input  hbt_pkg::ctrl_cmd_t                cmd,
    output hbt_pkg::ctrl_sts_t                sts
);
    import hbt_pkg::*;

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef struct packed {
        logic [MISS_W-1:0] miss;
        logic [TIME_W-1:0] seen;
    } entry_t;

    entry_t mem [TABLE_DEPTH];

    logic [TMO_W-1:0]       timeout_reg, timeout_next;
    logic [LIMIT_W-1:0]     limit_reg, limit_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] alive_reg, alive_next;
    op_t                    op_reg;
    logic [ID_W-1:0]        id_reg;
    logic                   in_range_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [LIVE_W-1:0]      live_reg, live_next;
    logic                   tmo_reg;
    logic                   close_reg, close_next;
    entry_t                 rd_data_reg;

    logic                   out_valid_reg, out_valid_next;
    kind_t                  out_kind_reg, out_kind_next;
    logic [ID_W-1:0]        out_id_reg, out_id_next;
    logic                   out_ok_reg, out_ok_next;
    logic [LIVE_W-1:0]      out_live_reg, out_live_next;
    logic                   out_last_reg, out_last_next;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    entry_t                 wr_data;

    logic [IDX_W-1:0]       id_idx;
    logic                   id_valid;
    logic                   out_free;
    logic [TIME_W-1:0]      elapsed;
    logic [MISS_W-1:0]      miss_new;
    logic                   alive_new;

    assign id_idx   = id_reg[IDX_W-1:0];
    assign id_valid = in_range_reg && valid_reg[id_idx];
    assign out_free = !out_valid_reg || m_ready;
    assign elapsed  = now_reg - rd_data_reg.seen;

    always_comb begin
        miss_new = rd_data_reg.miss;
        if (tmo_reg && (rd_data_reg.miss != MISS_MAX)) begin
            miss_new = rd_data_reg.miss + MISS_W'(1);
        end
        alive_new = alive_reg[idx_reg] && !(tmo_reg && (miss_new >= limit_reg));
    end

    assign sts.is_sweep      = (op_reg == OP_SWEEP);
    assign sts.idx_valid     = valid_reg[idx_reg];
    assign sts.idx_last      = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign sts.close_pending = close_reg;
    assign sts.out_free      = out_free;

    always_comb begin
        timeout_next   = timeout_reg;
        limit_next     = limit_reg;
        valid_next     = valid_reg;
        alive_next     = alive_reg;
        idx_next       = idx_reg;
        live_next      = live_reg;
        close_next     = close_reg;
        wr_en          = 1'b0;
        wr_addr        = id_idx;
        wr_data        = '{miss: '0, seen: now_reg};
        out_valid_next = out_valid_reg && !m_ready;
        out_kind_next  = out_kind_reg;
        out_id_next    = out_id_reg;
        out_ok_next    = out_ok_reg;
        out_live_next  = out_live_reg;
        out_last_next  = out_last_reg;

        if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_TIMEOUT: timeout_next = cfg_wdata[TMO_W-1:0];
                CFG_LIMIT:   limit_next   = cfg_wdata[LIMIT_W-1:0];
                default:     timeout_next = timeout_reg;
            endcase
        end

        if (cmd.load) begin
            idx_next  = '0;
            live_next = '0;
        end

        if (cmd.do_op) begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_STATUS;
            out_id_next    = id_reg;
            out_live_next  = '0;
            out_last_next  = 1'b1;
            out_ok_next    = 1'b0;
            if (in_range_reg) begin
                case (op_reg)
                    OP_ADD: begin
                        valid_next[id_idx] = 1'b1;
                        alive_next[id_idx] = 1'b1;
                        wr_en              = 1'b1;
                        out_ok_next        = 1'b1;
                    end
                    OP_REMOVE: begin
                        if (id_valid) begin
                            valid_next[id_idx] = 1'b0;
                            alive_next[id_idx] = 1'b0;
                            out_ok_next        = 1'b1;
                        end
                    end
                    OP_REFRESH: begin
                        if (id_valid) begin
                            wr_en       = 1'b1;
                            out_ok_next = 1'b1;
                        end
                    end
                    default: begin
                        out_ok_next = 1'b0;
                    end
                endcase
            end
        end

        if (cmd.sw_update) begin
            wr_en               = tmo_reg;
            wr_addr             = idx_reg;
            wr_data             = '{miss: miss_new, seen: now_reg};
            alive_next[idx_reg] = alive_new;
            close_next          = !alive_new;
            live_next           = live_reg + LIVE_W'(alive_new);
        end

        if (cmd.emit_close) begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_CLOSE;
            out_id_next    = ID_W'(idx_reg);
            out_ok_next    = 1'b0;
            out_live_next  = '0;
            out_last_next  = 1'b0;
        end

        if (cmd.advance) begin
            idx_next = idx_reg + IDX_W'(1);
        end

        if (cmd.emit_live) begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_LIVE;
            out_id_next    = '0;
            out_ok_next    = 1'b0;
            out_live_next  = live_reg;
            out_last_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= TIMEOUT_RESET;
            limit_reg     <= LIMIT_RESET;
            valid_reg     <= '0;
            alive_reg     <= '0;
            out_valid_reg <= 1'b0;
            close_reg     <= 1'b0;
            idx_reg       <= '0;
            live_reg      <= '0;
        end else begin
            timeout_reg   <= timeout_next;
            limit_reg     <= limit_next;
            valid_reg     <= valid_next;
            alive_reg     <= alive_next;
            out_valid_reg <= out_valid_next;
            close_reg     <= close_next;
            idx_reg       <= idx_next;
            live_reg      <= live_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= op_t'(s_operation);
            id_reg       <= s_connection_id;
            in_range_reg <= (s_connection_id < ID_W'(TABLE_DEPTH));
            now_reg      <= s_now_seconds;
        end
        if (cmd.sw_check) begin
            tmo_reg <= (elapsed > TIME_W'(timeout_reg));
        end
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_ok_reg   <= out_ok_next;
        out_live_reg <= out_live_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.sw_read) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_kind = out_kind_reg;
    assign m_target_id   = out_id_reg;
    assign m_ok          = out_ok_reg;
    assign m_live_count  = out_live_reg;
    assign m_last        = out_last_reg;

endmodule
